@@ hdl/ckc_pkg.sv @@
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared types and constants for the clock replacement key cache.
// ----------------------------------------------------------------------------
`default_nettype none

package ckc_pkg;

   // Field widths of the request and response words
   localparam int KEY_W    = 48;
   localparam int HANDLE_W = 32;
   localparam int SLOT_W   = 4;

   // Default number of cache entries
   localparam int ENTRIES_DEF = 16;

   // Request operation codes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SWEEP
   } state_type;

endpackage : ckc_pkg

`default_nettype wire

@@ hdl/clock_replacement_key_cache.sv @@
// ----------------------------------------------------------------------------
// clock_replacement_key_cache
// Fully associative key to handle cache with clock (second-chance)
// replacement; keys and handles sit in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage: raise start with a request word while busy is low. A lookup scans
// the entry memory one entry per clock (read, then compare in the next
// cycle), so a miss answers once the last entry is compared and a hit ends
// the scan early. An insert advances the clock hand one slot per clock,
// clearing use bits, and writes the first slot with a clear use bit. The
// response is shown for exactly one cycle with rsp_strobe and cannot be
// held off; busy falls as the strobe rises, so the next request may be
// accepted in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_replacement_key_cache #(
   parameter int ENTRIES = ckc_pkg::ENTRIES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request word
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic                          req_operation,
   input  wire logic [ckc_pkg::KEY_W-1:0]     req_lookup_key,
   input  wire logic [ckc_pkg::HANDLE_W-1:0]  req_object_handle,
   // response word
   output      logic                          rsp_strobe,
   output      logic                          rsp_hit,
   output      logic [ckc_pkg::HANDLE_W-1:0]  rsp_found_handle,
   output      logic [ckc_pkg::SLOT_W-1:0]    rsp_slot
);

   import ckc_pkg::*;

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = IDX_W + 1;
   localparam int ENTRY_W = KEY_W + HANDLE_W;

   // Entry memory: {key, handle}
   logic [ENTRY_W-1:0] entry_mem [ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Control state
   state_type            state_ff, state_in;
   logic [ENTRIES-1:0]   valid_ff;
   logic [ENTRIES-1:0]   use_ff;
   logic [IDX_W-1:0]     hand_ff;
   logic [CNT_W-1:0]     rd_idx_ff;
   logic                 cmp_vld_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;

   // Latched request
   logic                 op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [HANDLE_W-1:0]  handle_ff;

   // Response registers
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [HANDLE_W-1:0]  rsp_handle_ff, rsp_handle_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;

   // Datapath controls
   logic                 accept;
   logic                 issue;
   logic                 cmp_match;
   logic                 cmp_last;
   logic                 use_cur;
   logic                 mem_we;
   logic                 look_hit;
   logic                 sweep_clear;
   logic [IDX_W-1:0]     rd_addr;

   // Low slot bits of an entry index, zero-extended when the index is narrow
   function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
      logic [SLOT_W+IDX_W-1:0] ext;
      ext = {{SLOT_W{1'b0}}, idx};
      return ext[SLOT_W-1:0];
   endfunction

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign rd_addr   = rd_idx_ff[IDX_W-1:0];
   assign issue     = (state_ff == ST_LOOK) && (rd_idx_ff != CNT_W'(ENTRIES));
   assign cmp_match = cmp_vld_ff && valid_ff[cmp_idx_ff]
                      && (rd_data_ff[ENTRY_W-1:HANDLE_W] == key_ff);
   assign cmp_last  = cmp_vld_ff && (cmp_idx_ff == IDX_W'(ENTRIES - 1));
   assign use_cur   = use_ff[hand_ff];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_operation == OP_INSERT) ? ST_SWEEP : ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (cmp_match || cmp_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (!use_cur) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls and response word
   always_comb begin
      mem_we        = 1'b0;
      look_hit      = 1'b0;
      sweep_clear   = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_handle_in = '0;
      rsp_slot_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_LOOK: begin
            if (cmp_match) begin
               look_hit      = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_hit_in    = 1'b1;
               rsp_handle_in = rd_data_ff[HANDLE_W-1:0];
               rsp_slot_in   = to_slot(cmp_idx_ff);
            end else if (cmp_last) begin
               rsp_strobe_in = 1'b1;
            end
         end
         ST_SWEEP: begin
            if (use_cur) begin
               sweep_clear = 1'b1;
            end else begin
               mem_we        = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_slot_in   = to_slot(hand_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[hand_ff] <= {key_ff, handle_ff};
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // Latch the request word on acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_operation;
         key_ff    <= req_lookup_key;
         handle_ff <= req_object_handle;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         use_ff        <= '0;
         hand_ff       <= '0;
         rd_idx_ff     <= '0;
         cmp_vld_ff    <= 1'b0;
         cmp_idx_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;

         // scan pointer: restart on accept, advance while reads remain
         if (accept) begin
            rd_idx_ff  <= '0;
            cmp_vld_ff <= 1'b0;
         end else begin
            cmp_vld_ff <= issue;
            if (issue) begin
               cmp_idx_ff <= rd_addr;
               rd_idx_ff  <= rd_idx_ff + CNT_W'(1);
            end
         end

         // mark the matched entry as recently used
         if (look_hit) begin
            use_ff[cmp_idx_ff] <= 1'b1;
         end

         // advance the hand past used slots, clearing their use bits
         if (sweep_clear) begin
            use_ff[hand_ff] <= 1'b0;
            if (hand_ff == IDX_W'(ENTRIES - 1)) begin
               hand_ff <= '0;
            end else begin
               hand_ff <= hand_ff + IDX_W'(1);
            end
         end

         // claim the slot under the hand
         if (mem_we) begin
            valid_ff[hand_ff] <= 1'b1;
            use_ff[hand_ff]   <= 1'b1;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_hit_ff    <= rsp_hit_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_slot_ff   <= (op_ff == OP_INSERT || rsp_hit_in) ? rsp_slot_in : '0;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_found_handle = rsp_handle_ff;
   assign rsp_slot         = rsp_slot_ff;

endmodule : clock_replacement_key_cache

`default_nettype wire

@@ sim/ckc_reply_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ckc_reply_checker
// Watches the request and response channels of the key cache, keeps its own
// copy of the entries, use bits and clock hand, and compares every response
// word with the word predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------

module ckc_reply_checker #(
   parameter int ENTRIES = ckc_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_operation,
   input  logic [ckc_pkg::KEY_W-1:0]     req_lookup_key,
   input  logic [ckc_pkg::HANDLE_W-1:0]  req_object_handle,
   input  logic                          rsp_strobe,
   input  logic                          rsp_hit,
   input  logic [ckc_pkg::HANDLE_W-1:0]  rsp_found_handle,
   input  logic [ckc_pkg::SLOT_W-1:0]    rsp_slot,
   output int                            failures,
   output int                            pending
);

   import ckc_pkg::*;

   typedef struct packed {
      logic                hit;
      logic [HANDLE_W-1:0] handle;
      logic [SLOT_W-1:0]   slot;
   } cache_reply_type;

   // Mirror of the cache contents
   logic                line_valid  [ENTRIES];
   logic [KEY_W-1:0]    line_key    [ENTRIES];
   logic [HANDLE_W-1:0] line_handle [ENTRIES];
   logic                second_chance [ENTRIES];
   int                  hand;

   cache_reply_type replies_due[$];

   // Apply one request word to the mirror and return the response it causes
   function automatic cache_reply_type resolve_request(
      logic                op,
      logic [KEY_W-1:0]    key,
      logic [HANDLE_W-1:0] handle
   );
      cache_reply_type r;
      int n;
      r = '0;
      if (op == OP_LOOKUP) begin
         // first valid match in index order wins
         for (n = 0; n < ENTRIES; n++) begin
            if (line_valid[n] && line_key[n] == key) begin
               second_chance[n] = 1'b1;
               r.hit = 1'b1;
               r.handle = line_handle[n];
               r.slot = n[SLOT_W-1:0];
               return r;
            end
         end
         return r;
      end
      // advance the hand, clearing use bits, until a clear one turns up
      if (hand >= ENTRIES) hand = 0;
      for (n = 0; n <= ENTRIES && second_chance[hand]; n++) begin
         second_chance[hand] = 1'b0;
         hand = (hand + 1) % ENTRIES;
      end
      line_valid[hand] = 1'b1;
      line_key[hand] = key;
      line_handle[hand] = handle;
      second_chance[hand] = 1'b1;
      r.slot = hand[SLOT_W-1:0];
      return r;
   endfunction

   // Compare response words, then queue the prediction for a new request word
   always @(posedge clock) begin : watch
      cache_reply_type want;
      int errs;
      errs = 0;
      if (reset) begin
         for (int n = 0; n < ENTRIES; n++) begin
            line_valid[n] = 1'b0;
            line_key[n] = '0;
            line_handle[n] = '0;
            second_chance[n] = 1'b0;
         end
         hand = 0;
         replies_due.delete();
         failures <= 0;
      end else begin
         if (rsp_strobe) begin
            if (replies_due.size() == 0) begin
               errs++;
               $display("%0t: unexpected response word hit=%0b handle=%h slot=%0d",
                        $time, rsp_hit, rsp_found_handle, rsp_slot);
            end else begin
               want = replies_due.pop_front();
               if (rsp_hit !== want.hit) begin
                  errs++;
                  $display("%0t: hit mismatch, expected %0b actual %0b",
                           $time, want.hit, rsp_hit);
               end
               if (rsp_found_handle !== want.handle) begin
                  errs++;
                  $display("%0t: found_handle mismatch, expected %h actual %h",
                           $time, want.handle, rsp_found_handle);
               end
               if (rsp_slot !== want.slot) begin
                  errs++;
                  $display("%0t: slot mismatch, expected %0d actual %0d",
                           $time, want.slot, rsp_slot);
               end
            end
         end
         if (start && !busy)
            replies_due.push_back(resolve_request(req_operation, req_lookup_key,
                                                  req_object_handle));
         failures <= failures + errs;
      end
      pending <= replies_due.size();
   end

endmodule : ckc_reply_checker

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives lookup and insert words into the clock replacement key cache: a
// directed opening that fills the cache, hits duplicates and forces a full
// hand sweep, then random traffic over a small key pool with random sender
// gaps. The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------

module tb_top;

   import ckc_pkg::*;

   localparam int ENTRIES      = ENTRIES_DEF;
   localparam int RANDOM_WORDS = 1395;
   localparam int QUIET_TAIL   = 150;
   localparam int POOL_SIZE    = 20;
   localparam int STALL_LIMIT  = 4000;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_operation;
   logic [KEY_W-1:0]    req_lookup_key;
   logic [HANDLE_W-1:0] req_object_handle;
   logic                rsp_strobe;
   logic                rsp_hit;
   logic [HANDLE_W-1:0] rsp_found_handle;
   logic [SLOT_W-1:0]   rsp_slot;
   int                  failures;
   int                  pending;
   int                  stall_cycles;

   logic [KEY_W-1:0]    key_pool[POOL_SIZE];

   clock_replacement_key_cache #(
      .ENTRIES(ENTRIES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_lookup_key(req_lookup_key),
      .req_object_handle(req_object_handle),
      .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit),
      .rsp_found_handle(rsp_found_handle),
      .rsp_slot(rsp_slot)
   );

   ckc_reply_checker #(
      .ENTRIES(ENTRIES)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_lookup_key(req_lookup_key),
      .req_object_handle(req_object_handle),
      .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit),
      .rsp_found_handle(rsp_found_handle),
      .rsp_slot(rsp_slot),
      .failures(failures),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [KEY_W-1:0] any_key();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Present one request word and hold it until the block takes it
   task automatic send_word(logic op, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle);
      start <= 1'b1;
      req_operation <= op;
      req_lookup_key <= key;
      req_object_handle <= handle;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Look up fill keys, zero and all-ones so their first entries are marked used
   task automatic touch_all();
      for (int k = 3; k < ENTRIES; k++)
         send_word(OP_LOOKUP, {16'hC0DE, 32'(k)}, '0);
      send_word(OP_LOOKUP, '0, '0);
      send_word(OP_LOOKUP, '1, '0);
   endtask

   // Drop start for a while and scramble the request fields meanwhile
   task automatic hold_off(int cycles);
      repeat (cycles) begin
         start <= 1'b0;
         req_operation <= 1'($urandom);
         req_lookup_key <= any_key();
         req_object_handle <= $urandom;
         @(posedge clock);
      end
   endtask

   // Wait until every outstanding response word has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Count cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int idle_odds;
      logic op;
      logic [KEY_W-1:0] key;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_LOOKUP;
      req_lookup_key = '0;
      req_object_handle = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: misses on an empty cache, field extremes, duplicates
      send_word(OP_LOOKUP, '0, '1);
      send_word(OP_LOOKUP, '1, '0);
      send_word(OP_INSERT, '0, '0);
      send_word(OP_INSERT, '1, '1);
      send_word(OP_LOOKUP, '0, '1);
      send_word(OP_LOOKUP, '1, '0);
      send_word(OP_INSERT, '0, 32'hA5A5_5A5A);
      send_word(OP_LOOKUP, '0, '0);
      // fill the rest of the entries with distinct keys
      for (int k = 3; k < ENTRIES; k++)
         send_word(OP_INSERT, {16'hC0DE, 32'(k)}, $urandom);
      // mark all but the shadowed duplicate, then replace that duplicate
      touch_all();
      send_word(OP_INSERT, 48'h8000_0000_0002, 32'h8000_0002);
      // now every use bit ends up set
      touch_all();
      // full sweep: the hand clears every bit and lands where it started
      send_word(OP_INSERT, 48'h8000_0000_0001, 32'h8000_0001);
      send_word(OP_LOOKUP, '0, '0);
      send_word(OP_LOOKUP, any_key(), $urandom);
      drain();

      // Random: mostly pool keys so lookups hit and inserts evict
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int k = 2; k < POOL_SIZE; k++) key_pool[k] = any_key();
      idle_odds = 0;
      for (int w = 0; w < RANDOM_WORDS; w++) begin
         if (w % 64 == 0) idle_odds = $urandom_range(0, 4);
         if (w == RANDOM_WORDS / 2) drain();
         if (w < RANDOM_WORDS - QUIET_TAIL && idle_odds != 0
             && $urandom_range(0, idle_odds) == 0)
            hold_off($urandom_range(1, 16));
         if ($urandom_range(0, 15) == 0)
            key_pool[$urandom_range(0, POOL_SIZE - 1)] = any_key();
         op = ($urandom_range(0, 9) < 4) ? OP_INSERT : OP_LOOKUP;
         if ($urandom_range(0, 3) == 0)
            key = any_key();
         else
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         send_word(op, key, $urandom);
      end

      // Let the last responses arrive, then a few more cycles for strays
      drain();
      repeat (ENTRIES + 4) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule : tb_top
